>>> rtl/core/vat_pkg.sv
// Types and constants shared by the vertex affine transform unit.
// No dependencies; compile first.
package vat_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int NUM_LANES   = 6;

   typedef enum logic [2:0] {
      MODE_ROT_X     = 3'd0,
      MODE_ROT_Y     = 3'd1,
      MODE_ROT_Z     = 3'd2,
      MODE_SCALE     = 3'd3,
      MODE_TRANSLATE = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_SINE     = 3'd1,
      CSR_COSINE   = 3'd2,
      CSR_FACTOR_X = 3'd3,
      CSR_FACTOR_Y = 3'd4,
      CSR_FACTOR_Z = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      LANE_PASS,
      LANE_ROT,
      LANE_SCALE,
      LANE_ADD
   } lane_kind_type;

   // Per-lane operation: a*k0 +/- b*k1, or a*k0, or a+k0, or a.
   typedef struct packed {
      lane_kind_type      kind;
      logic               sub;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] k0;
      logic signed [15:0] k1;
   } lane_in_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic               end_of_mesh;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_vertex_x;
      logic signed [31:0] out_vertex_y;
      logic signed [31:0] out_vertex_z;
      logic signed [31:0] out_normal_x;
      logic signed [31:0] out_normal_y;
      logic signed [31:0] out_normal_z;
      logic               out_end_of_mesh;
   } rsp_type;

   localparam logic signed [15:0] SINE_RESET   = 16'sd0;
   localparam logic signed [15:0] COSINE_RESET = 16'sd16384;
   localparam logic signed [31:0] FACTOR_RESET = 32'sd65536;

endpackage

>>> rtl/core/vat_lane.sv
// One arithmetic lane: two stages, multiply, then sum, floor shift and saturate.
// Depends on vat_pkg.
module vat_lane (
   input  logic                clock,
   input  logic                en1,
   input  logic                en2,
   input  vat_pkg::lane_in_type lane_in,
   output logic signed [31:0]  lane_out
);
   import vat_pkg::*;

   localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
   localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

   logic signed [63:0] prod0;
   logic signed [47:0] prod1;
   logic signed [63:0] p0_in, p0_ff;
   logic signed [47:0] p1_in, p1_ff;
   logic               sub_ff;
   lane_kind_type      kind_ff;
   logic signed [64:0] p1_ext;
   logic signed [64:0] sum;
   logic signed [64:0] shifted;
   logic signed [31:0] res_in, res_ff;

   always_comb begin
      prod0 = lane_in.a * lane_in.k0;
      prod1 = lane_in.b * lane_in.k1;
      p1_in = '0;
      case (lane_in.kind)
         LANE_ROT: begin
            p0_in = prod0;
            p1_in = prod1;
         end
         LANE_SCALE: begin
            p0_in = prod0;
         end
         LANE_ADD: begin
            p0_in = $signed({{32{lane_in.a[31]}}, lane_in.a})
                  + $signed({{32{lane_in.k0[31]}}, lane_in.k0});
         end
         default: begin
            p0_in = $signed({{32{lane_in.a[31]}}, lane_in.a});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p0_ff   <= p0_in;
         p1_ff   <= p1_in;
         sub_ff  <= lane_in.sub;
         kind_ff <= lane_in.kind;
      end
   end

   always_comb begin
      p1_ext = $signed({{17{p1_ff[47]}}, p1_ff});
      sum    = $signed({p0_ff[63], p0_ff}) + (sub_ff ? -p1_ext : p1_ext);
      case (kind_ff)
         LANE_ROT:   shifted = sum >>> 14;
         LANE_SCALE: shifted = sum >>> 16;
         default:    shifted = sum;
      endcase
      if (shifted > SAT_MAX) begin
         res_in = 32'sh7FFF_FFFF;
      end else if (shifted < SAT_MIN) begin
         res_in = 32'sh8000_0000;
      end else begin
         res_in = shifted[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         res_ff <= res_in;
      end
   end

   assign lane_out = res_ff;

endmodule

>>> rtl/core/vat_merge.sv
// Merging stage: gathers the six lane results into one result beat and holds
// it in the output register. Depends on vat_pkg.
module vat_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [31:0]  lane_res [0:vat_pkg::NUM_LANES-1],
   input  logic                in_eom,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output vat_pkg::rsp_type    rsp_payload
);
   import vat_pkg::*;

   logic    valid_ff;
   rsp_type data_in, data_ff;

   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      data_in.out_vertex_x    = lane_res[0];
      data_in.out_vertex_y    = lane_res[1];
      data_in.out_vertex_z    = lane_res[2];
      data_in.out_normal_x    = lane_res[3];
      data_in.out_normal_y    = lane_res[4];
      data_in.out_normal_z    = lane_res[5];
      data_in.out_end_of_mesh = in_eom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

>>> rtl/core/vertex_affine_transform_unit.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_payload (vat_pkg::req_type)
// rsp     | out       | rsp_valid / rsp_ready | rsp_payload (vat_pkg::rsp_type)
// csr     | in        | csr_we                | csr_index, csr_wdata
//
// One corner per cycle when not stalled; the merge output register drives rsp_valid.
// Six lanes (vertex xyz, normal xyz) each run multiply, then sum/shift/saturate.
// Each stage advances when the one after it is empty or moving, so a bubble
// ahead lets a new beat in while the output register waits.
// Synchronous reset empties the pipeline and restores the register defaults.
// Depends on vat_pkg, vat_lane and vat_merge.
module vertex_affine_transform_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  vat_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output vat_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_we,
   input  logic [vat_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vat_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import vat_pkg::*;

   mode_type           mode_ff;
   logic signed [15:0] sine_ff;
   logic signed [15:0] cosine_ff;
   logic signed [31:0] factor_ff [0:2];

   logic signed [31:0] coord [0:1][0:2];
   logic [1:0]         rot_axis, p_axis, q_axis;
   lane_in_type        lane_in  [0:NUM_LANES-1];
   logic signed [31:0] lane_res [0:NUM_LANES-1];

   logic v1_ff, v2_ff, eom1_ff, eom2_ff;
   logic en1, en2, merge_ready;

   function automatic logic [1:0] next_axis(input logic [1:0] ax);
      next_axis = (ax == 2'd2) ? 2'd0 : ax + 2'd1;
   endfunction

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ROT_X;
         sine_ff      <= SINE_RESET;
         cosine_ff    <= COSINE_RESET;
         factor_ff[0] <= FACTOR_RESET;
         factor_ff[1] <= FACTOR_RESET;
         factor_ff[2] <= FACTOR_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:     mode_ff      <= mode_type'(csr_wdata[2:0]);
            CSR_SINE:     sine_ff      <= csr_wdata[15:0];
            CSR_COSINE:   cosine_ff    <= csr_wdata[15:0];
            CSR_FACTOR_X: factor_ff[0] <= csr_wdata;
            CSR_FACTOR_Y: factor_ff[1] <= csr_wdata;
            CSR_FACTOR_Z: factor_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign coord[0][0] = req_payload.vertex_x;
   assign coord[0][1] = req_payload.vertex_y;
   assign coord[0][2] = req_payload.vertex_z;
   assign coord[1][0] = req_payload.normal_x;
   assign coord[1][1] = req_payload.normal_y;
   assign coord[1][2] = req_payload.normal_z;

   // Rotation pair: p takes a*c - b*s, q takes a*s + b*c
   always_comb begin
      case (mode_ff)
         MODE_ROT_Y: rot_axis = 2'd1;
         MODE_ROT_Z: rot_axis = 2'd2;
         default:    rot_axis = 2'd0;
      endcase
      p_axis = next_axis(rot_axis);
      q_axis = next_axis(p_axis);
   end

   for (genvar gi = 0; gi < 2; gi++) begin : g_group
      for (genvar ki = 0; ki < 3; ki++) begin : g_axis
         always_comb begin
            lane_in[gi*3+ki].kind = LANE_PASS;
            lane_in[gi*3+ki].sub  = 1'b0;
            lane_in[gi*3+ki].a    = coord[gi][ki];
            lane_in[gi*3+ki].b    = '0;
            lane_in[gi*3+ki].k0   = factor_ff[ki];
            lane_in[gi*3+ki].k1   = '0;
            case (mode_ff)
               MODE_SCALE: begin
                  if (gi == 0) begin
                     lane_in[gi*3+ki].kind = LANE_SCALE;
                  end
               end
               MODE_TRANSLATE: begin
                  if (gi == 0) begin
                     lane_in[gi*3+ki].kind = LANE_ADD;
                  end
               end
               default: begin
                  if ((mode_ff inside {MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z}) &&
                      (2'(ki) != rot_axis)) begin
                     lane_in[gi*3+ki].kind = LANE_ROT;
                     lane_in[gi*3+ki].a    = coord[gi][p_axis];
                     lane_in[gi*3+ki].b    = coord[gi][q_axis];
                     if (2'(ki) == p_axis) begin
                        lane_in[gi*3+ki].sub = 1'b1;
                        lane_in[gi*3+ki].k0  = $signed({{16{cosine_ff[15]}}, cosine_ff});
                        lane_in[gi*3+ki].k1  = sine_ff;
                     end else begin
                        lane_in[gi*3+ki].k0  = $signed({{16{sine_ff[15]}}, sine_ff});
                        lane_in[gi*3+ki].k1  = cosine_ff;
                     end
                  end
               end
            endcase
         end
      end
   end

   // Stage control: advance into a stage that is empty or draining
   assign en2       = !v2_ff || merge_ready;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         eom1_ff <= req_payload.end_of_mesh;
      end
      if (en2) begin
         eom2_ff <= eom1_ff;
      end
   end

   for (genvar li = 0; li < NUM_LANES; li++) begin : g_lane
      vat_lane u_lane (
         .clock    (clock),
         .en1      (en1),
         .en2      (en2),
         .lane_in  (lane_in[li]),
         .lane_out (lane_res[li])
      );
   end

   vat_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (v2_ff),
      .in_ready    (merge_ready),
      .lane_res    (lane_res),
      .in_eom      (eom2_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/core/vat_checker.sv
// Port-level checks for the vertex affine transform unit, with its bind.
// Depends on vat_pkg and vertex_affine_transform_unit.
module vat_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input vat_pkg::rsp_type                rsp_payload
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat dropped or changed while stalled");

   // Input back-pressure only when the output register is full and stalled
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // With the sink draining, an accepted beat reaches the output in time
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("accepted beat did not reach the output");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind vertex_affine_transform_unit vat_checker u_vat_checker (.*);

>>> verif/vertex_affine_transform_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for vertex_affine_transform_unit: random and directed mesh corners
// through every mode, with a built-in transform predictor. Depends on vat_pkg and the RTL.
module vertex_affine_transform_unit_tb;
   import vat_pkg::*;

   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     SETTLE_LIMIT = 12;
   localparam int     PRINT_LIMIT  = 200;
   localparam longint Q_MAX        = 64'sd2147483647;
   localparam longint Q_MIN        = -64'sd2147483648;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_payload = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_payload;
   logic     csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the control registers
   logic [2:0]         mode_reg = MODE_ROT_X;
   logic signed [15:0] sin_coef = SINE_RESET;
   logic signed [15:0] cos_coef = COSINE_RESET;
   logic signed [31:0] factor_x = FACTOR_RESET;
   logic signed [31:0] factor_y = FACTOR_RESET;
   logic signed [31:0] factor_z = FACTOR_RESET;

   rsp_type pending_corners [$];
   rsp_type want;
   int      corners_sent = 0;
   int      results_seen = 0;
   int      mismatches   = 0;
   int      cycle_count  = 0;

   logic [15:0] stall_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   vertex_affine_transform_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic logic [31:0] clamp_q16(input longint v);
      if (v > Q_MAX) return 32'h7FFF_FFFF;
      if (v < Q_MIN) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // a*c - b*s, floored to Q16.16
   function automatic logic [31:0] turn_diff(input longint a, input longint b);
      longint c;
      longint s;
      c = cos_coef;
      s = sin_coef;
      return clamp_q16((a * c - b * s) >>> 14);
   endfunction

   // a*s + b*c, floored to Q16.16
   function automatic logic [31:0] turn_sum(input longint a, input longint b);
      longint c;
      longint s;
      c = cos_coef;
      s = sin_coef;
      return clamp_q16((a * s + b * c) >>> 14);
   endfunction

   function automatic rsp_type transform_corner(input req_type corner);
      longint  vx, vy, vz, nx, ny, nz, fx, fy, fz;
      rsp_type r;
      vx = $signed(corner.vertex_x);
      vy = $signed(corner.vertex_y);
      vz = $signed(corner.vertex_z);
      nx = $signed(corner.normal_x);
      ny = $signed(corner.normal_y);
      nz = $signed(corner.normal_z);
      fx = factor_x;
      fy = factor_y;
      fz = factor_z;
      r.out_vertex_x    = corner.vertex_x;
      r.out_vertex_y    = corner.vertex_y;
      r.out_vertex_z    = corner.vertex_z;
      r.out_normal_x    = corner.normal_x;
      r.out_normal_y    = corner.normal_y;
      r.out_normal_z    = corner.normal_z;
      r.out_end_of_mesh = corner.end_of_mesh;
      case (mode_reg)
         MODE_ROT_X: begin
            r.out_vertex_y = turn_diff(vy, vz);
            r.out_vertex_z = turn_sum(vy, vz);
            r.out_normal_y = turn_diff(ny, nz);
            r.out_normal_z = turn_sum(ny, nz);
         end
         MODE_ROT_Y: begin
            r.out_vertex_z = turn_diff(vz, vx);
            r.out_vertex_x = turn_sum(vz, vx);
            r.out_normal_z = turn_diff(nz, nx);
            r.out_normal_x = turn_sum(nz, nx);
         end
         MODE_ROT_Z: begin
            r.out_vertex_x = turn_diff(vx, vy);
            r.out_vertex_y = turn_sum(vx, vy);
            r.out_normal_x = turn_diff(nx, ny);
            r.out_normal_y = turn_sum(nx, ny);
         end
         MODE_SCALE: begin
            r.out_vertex_x = clamp_q16((vx * fx) >>> 16);
            r.out_vertex_y = clamp_q16((vy * fy) >>> 16);
            r.out_vertex_z = clamp_q16((vz * fz) >>> 16);
         end
         MODE_TRANSLATE: begin
            r.out_vertex_x = clamp_q16(vx + fx);
            r.out_vertex_y = clamp_q16(vy + fy);
            r.out_vertex_z = clamp_q16(vz + fz);
         end
         default: ;
      endcase
      return r;
   endfunction

   // register writes and accepted beats, both seen at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         mode_reg = MODE_ROT_X;
         sin_coef = SINE_RESET;
         cos_coef = COSINE_RESET;
         factor_x = FACTOR_RESET;
         factor_y = FACTOR_RESET;
         factor_z = FACTOR_RESET;
      end else begin
         if (req_valid && req_ready)
            pending_corners.push_back(transform_corner(req_payload));
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:     mode_reg = csr_wdata[2:0];
               CSR_SINE:     sin_coef = csr_wdata[15:0];
               CSR_COSINE:   cos_coef = csr_wdata[15:0];
               CSR_FACTOR_X: factor_x = csr_wdata;
               CSR_FACTOR_Y: factor_y = csr_wdata;
               CSR_FACTOR_Z: factor_z = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ---------------- result checking ----------------
   task automatic check_field(input string label, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t ns: %s expected %h actual %h", $time, label, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_corners.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result beat, expected none actual %h",
                     $time, rsp_payload);
         end else begin
            want = pending_corners.pop_front();
            check_field("vertex_x", want.out_vertex_x, rsp_payload.out_vertex_x);
            check_field("vertex_y", want.out_vertex_y, rsp_payload.out_vertex_y);
            check_field("vertex_z", want.out_vertex_z, rsp_payload.out_vertex_z);
            check_field("normal_x", want.out_normal_x, rsp_payload.out_normal_x);
            check_field("normal_y", want.out_normal_y, rsp_payload.out_normal_y);
            check_field("normal_z", want.out_normal_z, rsp_payload.out_normal_z);
            check_field("end_of_mesh", 32'(want.out_end_of_mesh),
                        32'(rsp_payload.out_end_of_mesh));
         end
      end
   end

   // receiver back-pressure: rotate a stall pattern, reload it now and then
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(3))
            0:       stall_pattern <= 16'hFFFF;
            1:       stall_pattern <= 16'($urandom);
            default: stall_pattern <= 16'($urandom) | 16'($urandom);
         endcase
         pattern_age <= $urandom_range(80, 16);
      end else begin
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
         pattern_age   <= pattern_age - 1;
      end
      rsp_ready <= stall_pattern[15];
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   function automatic logic [31:0] pick_coord();
      int mag;
      mag = $urandom_range(2097151);
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         3, 4:    return $urandom_range(1) ? 32'(-mag) : 32'(mag);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      int mag;
      mag = $urandom_range(524288);
      if ($urandom_range(3) == 0) return pick_coord();
      return $urandom_range(1) ? 32'(-mag) : 32'(mag);
   endfunction

   function automatic logic [15:0] pick_trig();
      case ($urandom_range(7))
         0:       return 16'sd16384;
         1:       return -16'sd16384;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(32768) - 16384);
      endcase
   endfunction

   function automatic req_type random_corner();
      req_type c;
      c.vertex_x    = pick_coord();
      c.vertex_y    = pick_coord();
      c.vertex_z    = pick_coord();
      c.normal_x    = pick_coord();
      c.normal_y    = pick_coord();
      c.normal_z    = pick_coord();
      c.end_of_mesh = ($urandom_range(7) == 0);
      return c;
   endfunction

   // leaves req_valid high; the caller lowers it when the burst ends
   task automatic push_corner(input req_type corner);
      req_valid   <= 1'b1;
      req_payload <= corner;
      corners_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] mode, input logic [15:0] sine,
                            input logic [15:0] cosine, input logic [31:0] fx,
                            input logic [31:0] fy, input logic [31:0] fz);
      put_reg(CSR_MODE, 32'(mode));
      put_reg(CSR_SINE, {{16{sine[15]}}, sine});
      put_reg(CSR_COSINE, {{16{cosine[15]}}, cosine});
      put_reg(CSR_FACTOR_X, fx);
      put_reg(CSR_FACTOR_Y, fy);
      put_reg(CSR_FACTOR_Z, fz);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (results_seen < corners_sent) @(posedge clock);
   endtask

   task automatic stream_corners(input int count);
      int sent;
      int burst;
      int gap;
      bit gapless;
      gapless = ($urandom_range(3) == 0);
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(16, 1);
         if (burst > count - sent) burst = count - sent;
         repeat (burst) push_corner(random_corner());
         sent += burst;
         gap = gapless ? 0 : $urandom_range(6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [2:0] mode, input logic [15:0] sine,
                            input logic [15:0] cosine, input logic [31:0] fx,
                            input logic [31:0] fy, input logic [31:0] fz,
                            input int count);
      configure(mode, sine, cosine, fx, fy, fz);
      stream_corners(count);
      wait_drained();
   endtask

   // full-scale, min-scale and mixed corners, back to back
   task automatic send_extremes();
      push_corner('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1});
      push_corner('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0});
      push_corner('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0001_0000, 32'h0000_0000, 32'h8000_0001, 1'b1});
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      send_extremes();
   endtask

   task automatic test_directed_settings();
      // saturating rotation, sine and cosine at one
      configure(MODE_ROT_X, 16'sd16384, 16'sd16384, FACTOR_RESET, FACTOR_RESET, FACTOR_RESET);
      send_extremes();
      // sine and cosine at the ends of the Q2.14 range: used as given
      configure(MODE_ROT_Y, 16'h8000, 16'h7FFF, FACTOR_RESET, FACTOR_RESET, FACTOR_RESET);
      send_extremes();
      configure(MODE_ROT_Z, -16'sd16384, -16'sd16384, FACTOR_RESET, FACTOR_RESET, FACTOR_RESET);
      send_extremes();
      configure(MODE_SCALE, SINE_RESET, COSINE_RESET, 32'h7FFF_FFFF, 32'h8000_0000,
                32'hFFFF_0000);
      send_extremes();
      configure(MODE_TRANSLATE, SINE_RESET, COSINE_RESET, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0);
      send_extremes();
      // unused mode code: everything passes through
      configure(MODE_SPARE_HI, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
      send_extremes();
   endtask

   task automatic test_rotation_random();
      repeat (4) begin
         run_phase(MODE_ROT_X, pick_trig(), pick_trig(), pick_coord(), pick_coord(),
                   pick_coord(), 45);
         run_phase(MODE_ROT_Y, pick_trig(), pick_trig(), pick_coord(), pick_coord(),
                   pick_coord(), 45);
         run_phase(MODE_ROT_Z, pick_trig(), pick_trig(), pick_coord(), pick_coord(),
                   pick_coord(), 45);
      end
   endtask

   task automatic test_scale_random();
      repeat (6)
         run_phase(MODE_SCALE, pick_trig(), pick_trig(), pick_scale(), pick_scale(),
                   pick_scale(), 45);
   endtask

   task automatic test_translate_random();
      repeat (6)
         run_phase(MODE_TRANSLATE, pick_trig(), pick_trig(), pick_coord(), pick_coord(),
                   pick_coord(), 45);
   endtask

   task automatic test_spare_modes();
      repeat (2)
         run_phase(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), pick_trig(), pick_trig(),
                   pick_coord(), pick_coord(), pick_coord(), 40);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_settings();
      test_rotation_random();
      test_scale_random();
      test_translate_random();
      test_spare_modes();
      // hold to catch stray result beats
      repeat (SETTLE_LIMIT) @(posedge clock);
      if (mismatches == 0 && pending_corners.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
